FILE: hw/rtl/mexp_pkg.sv
`default_nettype none

package mexp_pkg;

    // Datapath word and exponent widths.
    localparam int WORD_W   = 32;
    localparam int EXP_BITS = 32;
    localparam int CNT_W    = $clog2(WORD_W);

    // Configuration port.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC_EXP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIVATE_EXP = 2'd2;

    typedef logic [WORD_W-1:0]   t_word;
    typedef logic [EXP_BITS-1:0] t_exp;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } t_state;

    // Request to the shared modular multiplier.
    typedef struct packed {
        logic  start;
        t_word a;
        t_word b;
    } t_mul_req;

    // Response from the shared modular multiplier.
    typedef struct packed {
        logic  done;
        t_word prod;
    } t_mul_rsp;

endpackage

`default_nettype wire

FILE: hw/rtl/mexp_modmul.sv
`default_nettype none

// Bit-serial modular multiplier: one bit of b per cycle, MSB first.
// Each step computes acc = (2*acc + b_bit*a) mod n with a and acc below n.
module mexp_modmul (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mexp_pkg::t_word   i_modulus,
    input  wire mexp_pkg::t_mul_req i_req,
    output mexp_pkg::t_mul_rsp     o_rsp
);
    import mexp_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_word            r_acc;
    t_word            r_b;

    logic [WORD_W+1:0] w_sum;
    logic [WORD_W+2:0] w_sub1;
    logic [WORD_W+2:0] w_sub2;
    t_word             w_next;

    // One double-and-add step, reduced by subtracting n or 2n.
    always_comb begin
        w_sum  = {1'b0, r_acc, 1'b0}
               + (r_b[WORD_W-1] ? {2'b00, i_req.a} : {(WORD_W+2){1'b0}});
        w_sub1 = {1'b0, w_sum} - {3'b000, i_modulus};
        w_sub2 = {1'b0, w_sum} - {2'b00, i_modulus, 1'b0};
        if (!w_sub2[WORD_W+2]) begin
            w_next = w_sub2[WORD_W-1:0];
        end else if (!w_sub1[WORD_W+2]) begin
            w_next = w_sub1[WORD_W-1:0];
        end else begin
            w_next = w_sum[WORD_W-1:0];
        end
    end

    // Control: busy until the bit counter runs out, then a one-cycle done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WORD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Accumulator and multiplier shift register.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_b   <= i_req.b;
        end else if (r_busy) begin
            r_acc <= w_next;
            r_b   <= {r_b[WORD_W-2:0], 1'b0};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule

`default_nettype wire

FILE: hw/rtl/mexp_seq.sv
`default_nettype none

// Square-and-multiply sequencer. It reduces the base, then walks the
// exponent from the LSB, multiplying into the result for every set bit
// and squaring the running power while higher set bits remain.
module mexp_seq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire mexp_pkg::t_word    i_modulus,
    input  wire mexp_pkg::t_exp     i_exp,
    input  wire mexp_pkg::t_word    i_base,
    input  wire logic               i_eom,
    output logic                    o_idle,
    output logic                    o_res_valid,
    output mexp_pkg::t_word         o_result,
    output logic                    o_eom,
    input  wire logic               i_res_taken,
    output mexp_pkg::t_mul_req      o_mul_req,
    input  wire mexp_pkg::t_mul_rsp i_mul_rsp
);
    import mexp_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_pending;
    t_exp   r_ex;
    t_word  r_res;
    t_word  r_pw;
    logic   r_eom;

    logic w_n_zero;
    logic w_n_one;
    logic w_ex_zero;
    logic w_op_state;

    assign w_n_zero   = (i_modulus == '0);
    assign w_n_one    = (i_modulus == t_word'(1));
    assign w_ex_zero  = (i_exp == '0);
    assign w_op_state = (r_state == ST_REDUCE) || (r_state == ST_MUL)
                     || (r_state == ST_SQR);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = (w_n_zero || w_ex_zero) ? ST_DONE : ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (i_mul_rsp.done) begin
                    n_state = r_ex[0] ? ST_MUL : ST_SQR;
                end
            end
            ST_MUL: begin
                if (i_mul_rsp.done) begin
                    n_state = (r_ex[EXP_BITS-1:1] == '0) ? ST_DONE : ST_SQR;
                end
            end
            ST_SQR: begin
                if (i_mul_rsp.done) begin
                    n_state = r_ex[1] ? ST_MUL : ST_SQR;
                end
            end
            ST_DONE: begin
                if (i_res_taken) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and multiplier operands.
    always_comb begin
        o_idle          = 1'b0;
        o_res_valid     = 1'b0;
        o_mul_req.start = w_op_state && !r_pending;
        o_mul_req.b     = r_pw;
        o_mul_req.a     = r_pw;
        case (r_state)
            ST_IDLE:   o_idle = 1'b1;
            ST_REDUCE: o_mul_req.a = t_word'(1);
            ST_MUL:    o_mul_req.a = r_res;
            ST_SQR:    o_mul_req.a = r_pw;
            ST_DONE:   o_res_valid = 1'b1;
            default:   o_idle = 1'b0;
        endcase
    end

    assign o_result = r_res;
    assign o_eom    = r_eom;

    // State and outstanding-multiply flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pending <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_mul_req.start) begin
                r_pending <= 1'b1;
            end else if (i_mul_rsp.done) begin
                r_pending <= 1'b0;
            end
        end
    end

    // Operand registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    r_ex  <= i_exp;
                    r_pw  <= i_base;
                    r_eom <= i_eom;
                    if (w_n_zero) begin
                        r_res <= '0;
                    end else if (w_ex_zero) begin
                        r_res <= t_word'(1);
                    end else begin
                        r_res <= w_n_one ? '0 : t_word'(1);
                    end
                end
            end
            ST_REDUCE: begin
                if (i_mul_rsp.done) begin
                    r_pw <= i_mul_rsp.prod;
                end
            end
            ST_MUL: begin
                if (i_mul_rsp.done) begin
                    r_res <= i_mul_rsp.prod;
                end
            end
            ST_SQR: begin
                if (i_mul_rsp.done) begin
                    r_pw <= i_mul_rsp.prod;
                    r_ex <= {1'b0, r_ex[EXP_BITS-1:1]};
                end
            end
            default: begin
                r_ex <= r_ex;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/modular_exponentiation_unit.sv
`default_nettype none

// Channel   Direction  Signals                                Contents
// s_axis    in         tvalid tready tdata[31:0] tuser tlast  base_value, mode, end_of_message
// m_axis    out        tvalid tready tdata[31:0] tlast        result_value, end_of_message_out
// cfg       in         i_cfg_valid o_cfg_ready index data     0 modulus, 1 public, 2 private exp
//
// Each item takes one modular multiplication for the base reduction, one
// multiply per set exponent bit and one squaring per bit below the top set
// bit, all on the single bit-serial multiplier. A zero modulus or zero
// exponent skips the multiplier and goes straight to the done state.
// i_rst_n is synchronous; registers return to modulus 1 and zero exponents.
// s_axis_tready is high only while the sequencer is idle; a finished result
// waits in the output register while m_axis_tready is low.
module modular_exponentiation_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Input stream.
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [mexp_pkg::WORD_W-1:0]      s_axis_tdata,  // [31:0] base_value
    input  wire logic                             s_axis_tuser,  // [0] mode
    input  wire logic                             s_axis_tlast,  // end_of_message
    // Output stream.
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [mexp_pkg::WORD_W-1:0]           m_axis_tdata,  // [31:0] result_value
    output logic                                  m_axis_tlast,  // end_of_message_out
    // Configuration writes.
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [mexp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [mexp_pkg::WORD_W-1:0]      i_cfg_data
);
    import mexp_pkg::*;

    t_word    r_modulus;
    t_word    r_pub_exp;
    t_word    r_priv_exp;
    logic     r_out_valid;
    t_word    r_out_data;
    logic     r_out_last;

    logic     w_in_xfer;
    logic     w_out_load;
    logic     w_seq_idle;
    logic     w_seq_valid;
    t_word    w_seq_result;
    logic     w_seq_eom;
    t_exp     w_exp;
    t_mul_req w_mul_req;
    t_mul_rsp w_mul_rsp;

    // Configuration registers; writes are always accepted.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= t_word'(1);
            r_pub_exp  <= '0;
            r_priv_exp <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MODULUS:     r_modulus  <= i_cfg_data;
                CFG_PUBLIC_EXP:  r_pub_exp  <= i_cfg_data;
                CFG_PRIVATE_EXP: r_priv_exp <= i_cfg_data;
                default:         r_modulus  <= r_modulus;
            endcase
        end
    end

    // Input transfer and exponent select.
    assign s_axis_tready = w_seq_idle;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_exp         = s_axis_tuser ? r_priv_exp[EXP_BITS-1:0]
                                        : r_pub_exp[EXP_BITS-1:0];

    mexp_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_in_xfer),
        .i_modulus   (r_modulus),
        .i_exp       (w_exp),
        .i_base      (s_axis_tdata),
        .i_eom       (s_axis_tlast),
        .o_idle      (w_seq_idle),
        .o_res_valid (w_seq_valid),
        .o_result    (w_seq_result),
        .o_eom       (w_seq_eom),
        .i_res_taken (w_out_load),
        .o_mul_req   (w_mul_req),
        .i_mul_rsp   (w_mul_rsp)
    );

    mexp_modmul u_modmul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_modulus (r_modulus),
        .i_req     (w_mul_req),
        .o_rsp     (w_mul_rsp)
    );

    // Output register: loads when empty or being drained.
    assign w_out_load = w_seq_valid && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= w_seq_result;
            r_out_last <= w_seq_eom;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

FILE: tb/sv/modular_exponentiation_unit_tb.sv
`default_nettype none

module modular_exponentiation_unit_tb;
    import mexp_pkg::*;

    // Index that maps to no register; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam longint TIMEOUT_CYCLES = 4_000_000;
    localparam int IDLE_PERCENT = 6;

    typedef struct {
        logic  mode;
        t_word base;
        logic  eom;
    } t_symbol;

    typedef struct {
        t_word value;
        logic  eom;
    } t_power;

    typedef struct {
        logic [CFG_IDX_W-1:0] index;
        t_word                data;
    } t_reg_write;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [WORD_W-1:0]    s_axis_tdata = '0;   // [31:0] base_value
    logic                 s_axis_tuser = 1'b0; // [0] mode
    logic                 s_axis_tlast = 1'b0; // end_of_message
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [WORD_W-1:0]    m_axis_tdata;        // [31:0] result_value
    logic                 m_axis_tlast;        // end_of_message_out
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WORD_W-1:0]    i_cfg_data = '0;

    // Shadow copy of the key registers, as the block should hold them.
    t_word modulus_reg = 32'd1;
    t_word pub_exp_reg = '0;
    t_word priv_exp_reg = '0;

    t_symbol    pending_symbols[$];
    t_power     predicted_powers[$];
    t_reg_write pending_writes[$];

    logic no_gaps = 1'b0;
    int   n_symbols_sent = 0;
    int   n_powers_checked = 0;
    int   n_reg_writes = 0;
    int   n_mismatches = 0;

    modular_exponentiation_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Right-to-left square-and-multiply with the shadow key registers.
    function automatic t_word power_mod(logic mode, t_word base);
        logic [63:0] n;
        logic [63:0] e;
        logic [63:0] pw;
        logic [63:0] acc;
        n = {32'b0, modulus_reg};
        e = {32'b0, mode ? priv_exp_reg : pub_exp_reg};
        if (n == 0) begin
            return '0;
        end
        if (e == 0) begin
            return 32'd1;
        end
        pw = {32'b0, base} % n;
        acc = 64'd1 % n;
        for (int i = 0; i < EXP_BITS; i++) begin
            if (e[i]) begin
                acc = (acc * pw) % n;
            end
            pw = (pw * pw) % n;
        end
        return acc[WORD_W-1:0];
    endfunction

    // Symbol driver: predict on each transfer, then present the next symbol.
    always @(posedge i_clk) begin
        t_symbol sym;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predicted_powers.push_back('{power_mod(s_axis_tuser, s_axis_tdata),
                                             s_axis_tlast});
                n_symbols_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_symbols.size() != 0 &&
                    (no_gaps || $urandom_range(99) >= IDLE_PERCENT)) begin
                    sym = pending_symbols.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= sym.base;
                    s_axis_tuser  <= sym.mode;
                    s_axis_tlast  <= sym.eom;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Register write driver; the shadow copy follows each transfer.
    always @(posedge i_clk) begin
        t_reg_write wr;
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MODULUS:     modulus_reg = i_cfg_data;
                    CFG_PUBLIC_EXP:  pub_exp_reg = i_cfg_data;
                    CFG_PRIVATE_EXP: priv_exp_reg = i_cfg_data;
                    default: ;
                endcase
                n_reg_writes++;
            end
            if (!i_cfg_valid || o_cfg_ready) begin
                if (pending_writes.size() != 0) begin
                    wr = pending_writes.pop_front();
                    i_cfg_valid <= 1'b1;
                    i_cfg_index <= wr.index;
                    i_cfg_data  <= wr.data;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin
        t_power want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (predicted_powers.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %h/%b",
                             $time, m_axis_tdata, m_axis_tlast);
                    n_mismatches++;
                end else begin
                    want = predicted_powers.pop_front();
                    if (m_axis_tdata !== want.value) begin
                        $display("%0t: result_value mismatch: expected %h, actual %h",
                                 $time, want.value, m_axis_tdata);
                        n_mismatches++;
                    end
                    if (m_axis_tlast !== want.eom) begin
                        $display("%0t: end_of_message mismatch: expected %b, actual %b",
                                 $time, want.eom, m_axis_tlast);
                        n_mismatches++;
                    end
                    n_powers_checked++;
                end
            end
            m_axis_tready <= no_gaps || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    task automatic queue_symbol(logic mode, t_word base, logic eom);
        pending_symbols.push_back('{mode, base, eom});
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, t_word data);
        pending_writes.push_back('{index, data});
    endtask

    // Block until all writes and symbols are through and every result is back.
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (pending_writes.size() != 0 || i_cfg_valid ||
                   pending_symbols.size() != 0 || s_axis_tvalid ||
                   predicted_powers.size() != 0);
    endtask

    // Mostly short exponents keep the run fast; some use all 32 bits.
    function automatic t_word pick_exponent();
        int width;
        case ($urandom_range(9))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom() | 32'h8000_0000;
            default: begin
                width = $urandom_range(1, 16);
                return ($urandom() >> (32 - width)) | (32'd1 << (width - 1));
            end
        endcase
    endfunction

    function automatic t_word pick_modulus();
        case ($urandom_range(11))
            0: return '0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3, 4, 5: return $urandom_range(2, 65535);
            6, 7: return $urandom() | 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    // One message: a run of symbols in one mode, the last one flagged.
    // Now and then a symbol carries the other mode.
    task automatic queue_message(int len, t_word n);
        logic  mode;
        logic  sym_mode;
        t_word base;
        mode = 1'($urandom_range(1));
        for (int i = 0; i < len; i++) begin
            sym_mode = ($urandom_range(9) == 0) ? ~mode : mode;
            case ($urandom_range(9))
                0: base = '0;
                1: base = 32'hFFFF_FFFF;
                2: base = n;
                3, 4: base = (n > 1) ? $urandom_range(n - 1) : $urandom();
                default: base = $urandom();
            endcase
            queue_symbol(sym_mode, base, i == len - 1);
        end
    endtask

    initial begin
        int    target;
        int    queued;
        int    len;
        bit    paused;
        t_word n;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset keys: modulus one and zero exponents give one.
        queue_symbol(1'b0, 32'h0000_0000, 1'b0);
        queue_symbol(1'b1, 32'hFFFF_FFFF, 1'b1);
        wait_idle();

        // Widest modulus, all-ones and top-bit-only exponents; the unused
        // index must leave the modulus alone.
        write_reg(CFG_MODULUS, 32'hFFFF_FFFF);
        write_reg(CFG_PUBLIC_EXP, 32'hFFFF_FFFF);
        write_reg(CFG_PRIVATE_EXP, 32'h8000_0000);
        write_reg(CFG_UNUSED, 32'h0000_0000);
        wait_idle();
        queue_symbol(1'b0, 32'h0000_0000, 1'b0);
        queue_symbol(1'b1, 32'h0000_0001, 1'b0);
        queue_symbol(1'b0, 32'h0000_0002, 1'b0);
        queue_symbol(1'b1, 32'hFFFF_FFFF, 1'b1);
        queue_symbol(1'b0, 32'hFFFF_FFFE, 1'b0);
        queue_symbol(1'b1, 32'h1234_5678, 1'b1);
        queue_symbol(1'b0, 32'hFFFF_FFFF, 1'b1);
        queue_symbol(1'b1, 32'h0000_0000, 1'b0);
        wait_idle();

        // Modulus one: zero for a nonzero exponent, one for a zero exponent.
        write_reg(CFG_MODULUS, 32'd1);
        write_reg(CFG_PUBLIC_EXP, 32'd5);
        write_reg(CFG_PRIVATE_EXP, 32'd0);
        wait_idle();
        queue_symbol(1'b0, 32'hDEAD_BEEF, 1'b0);
        queue_symbol(1'b1, 32'hDEAD_BEEF, 1'b1);
        wait_idle();

        // Modulus zero gives zero whatever the exponent.
        write_reg(CFG_MODULUS, 32'd0);
        write_reg(CFG_PUBLIC_EXP, 32'd3);
        wait_idle();
        queue_symbol(1'b0, 32'h0000_0007, 1'b0);
        queue_symbol(1'b1, 32'h0000_0007, 1'b1);
        wait_idle();

        // A small textbook key pair: encrypt, then decrypt the ciphertext.
        write_reg(CFG_MODULUS, 32'd3233);
        write_reg(CFG_PUBLIC_EXP, 32'd17);
        write_reg(CFG_PRIVATE_EXP, 32'd2753);
        wait_idle();
        queue_symbol(1'b0, 32'd65, 1'b0);
        queue_symbol(1'b0, 32'd3232, 1'b1);
        queue_symbol(1'b1, 32'd2790, 1'b0);
        queue_symbol(1'b1, 32'd3233, 1'b1);
        wait_idle();

        // Power-of-two modulus with exponents one and two.
        write_reg(CFG_MODULUS, 32'h8000_0000);
        write_reg(CFG_PUBLIC_EXP, 32'd1);
        write_reg(CFG_PRIVATE_EXP, 32'd2);
        wait_idle();
        queue_symbol(1'b0, 32'hFFFF_FFFF, 1'b0);
        queue_symbol(1'b1, 32'hFFFF_FFFF, 1'b1);
        wait_idle();

        // Random keys per phase; each phase sends messages, pausing once
        // halfway until the block has drained. One phase runs without gaps.
        for (int phase = 0; phase < 10; phase++) begin
            no_gaps = (phase == 4);
            n = pick_modulus();
            write_reg(CFG_MODULUS, n);
            write_reg(CFG_PUBLIC_EXP, pick_exponent());
            write_reg(CFG_PRIVATE_EXP, pick_exponent());
            if ($urandom_range(3) == 0) begin
                write_reg(CFG_UNUSED, $urandom());
            end
            wait_idle();
            target = $urandom_range(20, 30);
            queued = 0;
            paused = 1'b0;
            while (queued < target) begin
                len = $urandom_range(1, 8);
                if (len > target - queued) begin
                    len = target - queued;
                end
                queue_message(len, n);
                queued += len;
                if (!paused && queued >= target / 2) begin
                    wait_idle();
                    paused = 1'b1;
                end
            end
            wait_idle();
        end
        no_gaps = 1'b0;

        repeat (50) @(posedge i_clk);
        $display("Sent %0d symbols through %0d register writes; %0d results checked.",
                 n_symbols_sent, n_reg_writes, n_powers_checked);
        $display("Keys covered reset values, zero and one moduli, full-width exponents.");
        if (n_mismatches == 0 && predicted_powers.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(TIMEOUT_CYCLES * 10);
        $display("%0t: timeout with %0d results outstanding",
                 $time, predicted_powers.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
